[sv/bmorph_pkg.sv]
// Shared types and constants of the 3x3 binary morphology core.
// Used by every module of the block but bmorph_ram; depends on nothing else.
package bmorph_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 16;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    localparam logic [PIX_W-1:0]      PIX_ON       = 8'd255;
    localparam logic [PIX_W-1:0]      PIX_OFF      = 8'd0;
    localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [IMG_H_BITS-1:0] MIN_HEIGHT   = 16'd3;

    typedef enum logic [1:0] {
        REG_OP_MODE      = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        MODE_ERODE  = 1'b0,
        MODE_DILATE = 1'b1
    } op_mode_t;

    typedef struct packed {
        logic emit;
        logic fwd;
        logic border;
        logic frame_end;
    } s1_ctrl_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } out_word_t;

endpackage

[sv/bmorph_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the two line stores; depends on nothing else.
module bmorph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/bmorph_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Recomputes the output row and column after a register write; uses bmorph_pkg.
module bmorph_div
    import bmorph_pkg::*;
#(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            dq_next   = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg || done_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

[sv/bmorph_window.sv]
// 3x3 window registers and the erode/dilate decision for one word.
// Takes line store read data from the top level; uses bmorph_pkg.
module bmorph_window
    import bmorph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  s1_ctrl_t         ctrl,
    input  logic             op_mode,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] a_rdata,
    input  logic [PIX_W-1:0] b_rdata,
    input  logic [PIX_W-1:0] fwd_mid,
    input  logic [PIX_W-1:0] fwd_top,
    output logic [PIX_W-1:0] mid,
    output logic             push,
    output out_word_t        push_word
);

    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] top;
    logic             any_off;
    logic             any_on;
    logic [PIX_W-1:0] res;

    always_comb
    begin
        mid = ctrl.fwd ? fwd_mid : a_rdata;
        top = ctrl.fwd ? fwd_top : b_rdata;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top;
        win_next[1][2] = mid;
        win_next[2][2] = pixel;
    end

    always_comb
    begin
        any_off = 1'b0;
        any_on  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                any_off = any_off || (win_next[i][j] == PIX_OFF);
                any_on  = any_on  || (win_next[i][j] == PIX_ON);
            end
        end
        if (ctrl.border)
        begin
            res = win_next[1][1];
        end
        else if (op_mode_t'(op_mode) == MODE_DILATE)
        begin
            res = any_on ? PIX_ON : PIX_OFF;
        end
        else
        begin
            res = any_off ? PIX_OFF : PIX_ON;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (valid)
        begin
            win_reg <= win_next;
        end
    end

    assign push                = valid && ctrl.emit;
    assign push_word.pixel     = res;
    assign push_word.frame_end = ctrl.frame_end;

endmodule

[sv/bmorph_outq.sv]
// Small result queue that decouples the window stage from the output channel.
// Holds finished words while the consumer stalls; uses bmorph_pkg.
module bmorph_outq
    import bmorph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  out_word_t             push_word,
    input  logic                  pop_ready,
    output logic                  head_valid,
    output out_word_t             head_word,
    output logic [OUTQ_CNT_W-1:0] count
);

    out_word_t             slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign pop = head_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OUTQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_word  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

[sv/binary_morphology_3x3_core.sv]
// Top level of the streaming 3x3 binary erosion/dilation core.
// Uses bmorph_pkg, bmorph_ram, bmorph_div, bmorph_window and bmorph_outq.
//
//   Channel  Signals                                     Direction
//   input    in_valid, in_ready, in_pixel, drain         word into the core
//   output   out_valid, out_ready, out_pixel, frame_end  word out of the core
//   config   psel, penable, pwrite, paddr, pwdata,       register access
//            prdata, pready
//
// One input word is accepted per clock while in_ready is high; a result passes the
// registered line store read and the window stage, then waits in the output queue.
// Reset clears all control state; the line stores are not cleared and need no pass.
// Every register write holds off input words while the serial divider recomputes
// the output row/column. A stalled output fills a four-word queue; input is held off
// once it cannot take more.
module binary_morphology_3x3_core
    import bmorph_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   in_pixel,
    input  logic               drain,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   out_pixel,
    output logic               frame_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
    localparam int CNT_W = WW + IMG_H_BITS;
    localparam int ROW_W = CNT_W - 1;

    // Configuration registers.
    logic                  op_mode_reg, op_mode_next;
    logic [IMG_W_BITS-1:0] image_width_reg, image_width_next;
    logic [IMG_H_BITS-1:0] image_height_reg, image_height_next;
    logic                  cfg_start_reg;
    logic                  cfg_wr;

    // Frame position state.
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [IMG_H_BITS-1:0] in_row_reg, in_row_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic [ROW_W-1:0]      out_r_reg, out_r_next;
    logic [COL_W-1:0]      out_c_reg, out_c_next;
    logic [CNT_W-1:0]      total_reg;

    // Window stage registers.
    logic                  s1_valid_reg;
    s1_ctrl_t              s1_ctrl_reg, s1_ctrl_next;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIX_W-1:0]      s1_pixel_reg;
    logic [PIX_W-1:0]      fwd_mid_reg;
    logic [PIX_W-1:0]      fwd_top_reg;

    logic [CW-1:0]         wx;
    logic [WW-1:0]         eff_w;
    logic [IMG_H_BITS-1:0] eff_h;
    logic                  flushing, take, act, emit_a, wrap, last, border_a, fwd_a;
    logic                  c_wrap;
    logic [COL_W-1:0]      col_a;
    logic [WW-1:0]         col_inc;
    logic [WW-1:0]         c_inc;
    logic [PIX_W-1:0]      pix_a;

    logic                  div_busy, div_done;
    logic [CNT_W-1:0]      div_q;
    logic [WW-1:0]         div_rem;

    logic [PIX_W-1:0]      a_rdata, b_rdata, mid_eff;
    logic                  push;
    out_word_t             push_word, head_word;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic                  s1_pend;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        op_mode_next      = op_mode_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_OP_MODE:      op_mode_next      = pwdata[0];
                REG_IMAGE_WIDTH:  image_width_next  = pwdata[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_next = pwdata[IMG_H_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_OP_MODE:      prdata = PDATA_W'(op_mode_reg);
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size.
    always_comb
    begin
        wx = CW'(image_width_reg);
        if (wx < CW'(3))
        begin
            eff_w = WW'(3);
        end
        else if (wx > CW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(wx);
        end
        eff_h = (image_height_reg < MIN_HEIGHT) ? MIN_HEIGHT : image_height_reg;
    end

    // Input side decode.
    assign s1_pend  = s1_valid_reg && s1_ctrl_reg.emit;
    assign in_ready = !cfg_start_reg && !div_busy
                      && ((q_count + OUTQ_CNT_W'(s1_pend)) <= OUTQ_CNT_W'(OUTQ_DEPTH - 1));
    assign take     = in_valid && in_ready;
    assign flushing = in_row_reg >= eff_h;
    assign act      = take && (flushing || !drain);
    assign pix_a    = flushing ? PIX_OFF : in_pixel;
    assign col_a    = (WW'(in_col_reg) >= eff_w) ? '0 : in_col_reg;
    assign col_inc  = WW'(col_a) + WW'(1);
    assign wrap     = col_inc >= eff_w;
    assign emit_a   = flushing || (in_row_reg >= IMG_H_BITS'(2))
                      || (in_row_reg == IMG_H_BITS'(1) && col_a != '0);
    assign last     = out_count_reg >= (total_reg - CNT_W'(1));
    assign border_a = (WW'(out_c_reg) == eff_w - WW'(1)) || (out_c_reg == '0)
                      || (out_r_reg == '0) || (out_r_reg >= ROW_W'(eff_h - IMG_H_BITS'(1)));
    assign fwd_a    = s1_valid_reg && (s1_col_reg == col_a);
    assign c_inc    = WW'(out_c_reg) + WW'(1);
    assign c_wrap   = c_inc >= eff_w;

    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        out_r_next     = out_r_reg;
        out_c_next     = out_c_reg;
        if (div_done)
        begin
            out_r_next = ROW_W'(div_q);
            out_c_next = COL_W'(div_rem);
        end
        if (act)
        begin
            if (emit_a && last)
            begin
                in_col_next    = '0;
                in_row_next    = '0;
                out_count_next = '0;
                out_r_next     = '0;
                out_c_next     = '0;
            end
            else
            begin
                in_col_next = wrap ? '0 : col_inc[COL_W-1:0];
                if (wrap && in_row_reg < eff_h)
                begin
                    in_row_next = in_row_reg + IMG_H_BITS'(1);
                end
                if (emit_a)
                begin
                    out_count_next = out_count_reg + CNT_W'(1);
                    if (c_wrap)
                    begin
                        out_c_next = '0;
                        out_r_next = out_r_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_c_next = c_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_ctrl_next.emit      = emit_a;
        s1_ctrl_next.fwd       = fwd_a;
        s1_ctrl_next.border    = border_a;
        s1_ctrl_next.frame_end = emit_a && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg      <= 1'b0;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            cfg_start_reg    <= 1'b0;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_count_reg    <= '0;
            out_r_reg        <= '0;
            out_c_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s1_ctrl_reg      <= '0;
        end
        else
        begin
            op_mode_reg      <= op_mode_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            cfg_start_reg    <= cfg_wr;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_count_reg    <= out_count_next;
            out_r_reg        <= out_r_next;
            out_c_reg        <= out_c_next;
            s1_valid_reg     <= act;
            if (act)
            begin
                s1_ctrl_reg <= s1_ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= CNT_W'(eff_w) * CNT_W'(eff_h);
        if (act)
        begin
            s1_col_reg   <= col_a;
            s1_pixel_reg <= pix_a;
            fwd_mid_reg  <= s1_pixel_reg;
            fwd_top_reg  <= mid_eff;
        end
    end

    bmorph_div #(
        .DIVIDEND_W (CNT_W),
        .DIVISOR_W  (WW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_start_reg),
        .dividend  (out_count_reg),
        .divisor   (eff_w),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    bmorph_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (act),
        .raddr (col_a),
        .rdata (a_rdata)
    );

    bmorph_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (act),
        .raddr (col_a),
        .rdata (b_rdata)
    );

    bmorph_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (s1_valid_reg),
        .ctrl      (s1_ctrl_reg),
        .op_mode   (op_mode_reg),
        .pixel     (s1_pixel_reg),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .fwd_mid   (fwd_mid_reg),
        .fwd_top   (fwd_top_reg),
        .mid       (mid_eff),
        .push      (push),
        .push_word (push_word)
    );

    bmorph_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop_ready  (out_ready),
        .head_valid (out_valid),
        .head_word  (head_word),
        .count      (q_count)
    );

    assign out_pixel = head_word.pixel;
    assign frame_end = head_word.frame_end;

endmodule

[sim/binary_morphology_3x3_core_tb.sv]
// Self-checking testbench for binary_morphology_3x3_core: streams binary frames under many
// register settings with random idling on both channels and checks every output word.
// Depends on bmorph_pkg and the core RTL only.
module binary_morphology_3x3_core_tb;
    import bmorph_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          MAX_COLS     = 1024;
    localparam int          RANDOM_WORDS = 820;
    localparam int          SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          MAX_REPORTS  = 50;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             drain;
    } src_word_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   in_pixel  = '0;
    logic               drain     = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [PIX_W-1:0]   out_pixel;
    logic               frame_end;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    src_word_t   pending_pixels[$];
    out_word_t   expected_pixels[$];
    src_word_t   next_word;
    out_word_t   want_word;
    int unsigned src_gap     = 0;
    int unsigned sink_stall  = 0;
    int unsigned next_stall  = 0;
    bit          no_idle     = 1'b0;
    int          n_queued    = 0;
    int          n_ignored   = 0;
    int          n_accepted  = 0;
    int          n_checked   = 0;
    int          n_errors    = 0;
    int          n_writes    = 0;
    int          n_frames    = 0;
    int unsigned n_cycles    = 0;

    op_mode_t              cfg_mode;
    logic [IMG_W_BITS-1:0] cfg_width;
    logic [IMG_H_BITS-1:0] cfg_height;
    logic [PIX_W-1:0]      line_a [MAX_COLS];
    logic [PIX_W-1:0]      line_b [MAX_COLS];
    logic [PIX_W-1:0]      win [3][3];
    int unsigned           col_pos;
    int unsigned           row_pos;
    int unsigned           out_idx;

    binary_morphology_3x3_core #(
        .MAX_WIDTH(MAX_COLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pixel  (in_pixel),
        .drain     (drain),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .frame_end (frame_end),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic int unsigned frame_cols();
        if (cfg_width < 3)
            return 3;
        if (cfg_width > MAX_COLS)
            return MAX_COLS;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned frame_rows();
        return (cfg_height < MIN_HEIGHT) ? 3 : 32'(cfg_height);
    endfunction

    // Advances the window by one accepted word and queues the output word it yields, if any.
    task automatic predict_morph_word(input logic [PIX_W-1:0] pix, input logic drn);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      p;
        int               i;
        int               j;
        logic             flushing;
        logic             emit;
        logic             hit;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] prev_right;
        logic [PIX_W-1:0] target;
        out_word_t        ow;
        w = frame_cols();
        h = frame_rows();
        flushing = (row_pos >= h);
        if (flushing || !drn)
        begin
            v = flushing ? PIX_OFF : pix;
            if (col_pos >= w)
                col_pos = 0;
            col = col_pos;
            emit = flushing || row_pos >= 2 || (row_pos == 1 && col >= 1);
            prev_right = win[1][2];
            top = line_b[col];
            mid = line_a[col];
            line_b[col] = mid;
            line_a[col] = v;
            for (i = 0; i < 3; i++)
            begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = v;
            col_pos = col + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                if (row_pos < h)
                    row_pos++;
            end
            if (emit)
            begin
                p = out_idx;
                if (p % w == w - 1)
                    ow.pixel = prev_right;
                else if (p / w == 0 || p / w >= h - 1 || p % w == 0)
                    ow.pixel = win[1][1];
                else
                begin
                    target = (cfg_mode == MODE_ERODE) ? PIX_OFF : PIX_ON;
                    hit = 1'b0;
                    for (i = 0; i < 3; i++)
                        for (j = 0; j < 3; j++)
                            hit = hit | (win[i][j] == target);
                    ow.pixel = hit ? target : ~target;
                end
                if (p >= w * h - 1)
                begin
                    ow.frame_end = 1'b1;
                    col_pos = 0;
                    row_pos = 0;
                    out_idx = 0;
                    n_frames++;
                end
                else
                begin
                    ow.frame_end = 1'b0;
                    out_idx = p + 1;
                end
                expected_pixels.push_back(ow);
            end
        end
    endtask

    task automatic cfg_check(input reg_idx_t idx);
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] got;
        case (idx)
            REG_OP_MODE:     want = PDATA_W'(cfg_mode);
            REG_IMAGE_WIDTH: want = PDATA_W'(cfg_width);
            default:         want = PDATA_W'(cfg_height);
        endcase
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: register %s read back %h, expected %h",
                         $time, idx.name(), got, want);
        end
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_OP_MODE:     cfg_mode = op_mode_t'(value[0]);
            REG_IMAGE_WIDTH: cfg_width = value[IMG_W_BITS-1:0];
            default:         cfg_height = value[IMG_H_BITS-1:0];
        endcase
        n_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_check(idx);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(input op_mode_t mode, input int unsigned width_val,
                                input int unsigned height_val);
        wait_drained();
        cfg_write(REG_OP_MODE, PDATA_W'(mode));
        cfg_write(REG_IMAGE_WIDTH, PDATA_W'(width_val));
        cfg_write(REG_IMAGE_HEIGHT, PDATA_W'(height_val));
    endtask

    task automatic queue_word(input logic [PIX_W-1:0] pix, input logic drn);
        src_word_t sw;
        sw.pixel = pix;
        sw.drain = drn;
        pending_pixels.push_back(sw);
        n_queued++;
    endtask

    // Pixels are 255 with the given percentage; noisy frames add stray values and ignored drains.
    task automatic send_pixels(input int unsigned count, input int unsigned density,
                               input bit noisy);
        int unsigned k;
        for (k = 0; k < count; k++)
        begin
            if (noisy && $urandom_range(29, 0) == 0)
            begin
                queue_word(PIX_W'($urandom_range(255, 0)), 1'b1);
                n_ignored++;
            end
            if (noisy && $urandom_range(19, 0) == 0)
                queue_word(PIX_W'($urandom_range(255, 0)), 1'b0);
            else
                queue_word(($urandom_range(99, 0) < density) ? PIX_ON : PIX_OFF, 1'b0);
        end
    endtask

    task automatic send_flush(input int unsigned count, input bit noisy);
        int unsigned k;
        for (k = 0; k < count; k++)
            queue_word(PIX_W'($urandom_range(255, 0)),
                       noisy ? ($urandom_range(3, 0) != 0) : 1'b1);
    endtask

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_pixel <= '0;
            drain <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_morph_word(in_pixel, drain);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_word = pending_pixels.pop_front();
                    in_pixel <= next_word.pixel;
                    drain <= next_word.drain;
                    in_valid <= 1'b1;
                    src_gap <= no_idle ? 0 : $urandom_range(5, 0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected word: expected none, got %h frame_end %b",
                                 $time, out_pixel, frame_end);
                end
                else
                begin
                    want_word = expected_pixels.pop_front();
                    n_checked++;
                    if (out_pixel !== want_word.pixel || frame_end !== want_word.frame_end)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: expected %h frame_end %b, got %h frame_end %b",
                                     $time, want_word.pixel, want_word.frame_end,
                                     out_pixel, frame_end);
                    end
                end
                next_stall = no_idle ? 0 : $urandom_range(5, 0);
            end
            else
                next_stall = (sink_stall == 0) ? 0 : sink_stall - 1;
            sink_stall <= next_stall;
            out_ready <= (next_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     n_cycles, expected_pixels.size());
            $display("binary_morphology_3x3_core verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned wv;
        int unsigned hv;
        int          start_count;
        int          start_ignored;
        int          frames_before;
        int          r;
        int          c;
        cfg_mode = MODE_ERODE;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        out_idx = 0;
        for (c = 0; c < MAX_COLS; c++)
        begin
            line_a[c] = PIX_OFF;
            line_b[c] = PIX_OFF;
        end
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                win[r][c] = PIX_OFF;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        cfg_check(REG_OP_MODE);
        cfg_check(REG_IMAGE_WIDTH);
        cfg_check(REG_IMAGE_HEIGHT);

        // Erosion treats only zero as background, so stray corner values keep the center set.
        set_geometry(MODE_ERODE, 3, 3);
        queue_word(8'h80, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_OFF, 1'b1);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(8'h01, 1'b0);
        queue_word(PIX_ON, 1'b0);
        queue_word(PIX_OFF, 1'b1);
        queue_word(PIX_OFF, 1'b1);
        queue_word(PIX_OFF, 1'b1);

        // Dilation must see a set pixel in the last neighbor row.
        set_geometry(MODE_DILATE, 3, 3);
        queue_word(PIX_OFF, 1'b0);
        queue_word(8'h7F, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_OFF, 1'b0);
        queue_word(PIX_ON, 1'b0);
        send_flush(4, 1'b0);

        // Mode flip in the middle of a frame, with the input held until the output is drained.
        set_geometry(MODE_ERODE, 6, 5);
        send_pixels(14, 60, 1'b0);
        wait_drained();
        cfg_write(REG_OP_MODE, PDATA_W'(MODE_DILATE));
        send_pixels(16, 40, 1'b0);
        send_flush(7, 1'b0);

        // Tallest frame, cut short by lowering the height below the rows already sent.
        set_geometry(MODE_ERODE, 1, 65535);
        send_pixels(15, 70, 1'b1);
        wait_drained();
        cfg_write(REG_IMAGE_HEIGHT, 2);
        frames_before = n_frames;
        while (n_frames == frames_before)
        begin
            queue_word(PIX_W'($urandom_range(255, 0)), 1'b1);
            while (n_accepted != n_queued)
                @(posedge clk);
        end

        start_count = n_queued;
        start_ignored = n_ignored;
        while ((n_queued - start_count) - (n_ignored - start_ignored) < RANDOM_WORDS)
        begin
            if ($urandom_range(9, 0) < 7)
            begin
                case ($urandom_range(9, 0))
                    0:       wv = $urandom_range(2, 0);
                    1:       wv = $urandom_range(64, 16);
                    default: wv = $urandom_range(10, 3);
                endcase
                if ($urandom_range(9, 0) == 0)
                    hv = $urandom_range(2, 0);
                else
                    hv = $urandom_range((wv > 12) ? 4 : 8, 3);
                set_geometry(op_mode_t'($urandom_range(1, 0)), wv, hv);
            end
            no_idle = ($urandom_range(3, 0) == 0);
            send_pixels(frame_cols() * frame_rows(), $urandom_range(95, 5), 1'b1);
            send_flush(frame_cols() + 1, 1'b1);
        end

        wait_drained();
        $display("Checked %0d output words from %0d input words over %0d frames.",
                 n_checked, n_accepted, n_frames);
        $display("Both modes, widths 3 to 64, heights 3 to 65535, %0d register writes; %0d errors.",
                 n_writes, n_errors);
        if (n_errors == 0)
            $display("binary_morphology_3x3_core verification clean");
        else
            $display("binary_morphology_3x3_core verification failed");
        $finish;
    end

endmodule

[sim.f]
sv/bmorph_pkg.sv
sv/bmorph_ram.sv
sv/bmorph_div.sv
sv/bmorph_window.sv
sv/bmorph_outq.sv
sv/binary_morphology_3x3_core.sv
sim/binary_morphology_3x3_core_tb.sv
